[rtl/core/smv_pkg.sv]
// ----------------------------------------------------------------------------
// smv_pkg
// Shared widths, register indexes and types of the screen motion vector core.
// ----------------------------------------------------------------------------
`default_nettype none

package smv_pkg;

    localparam int POS_W   = 24;             // Q12.12 world coordinate
    localparam int COEF_W  = 16;             // Q4.12 matrix coefficient
    localparam int PROD_W  = POS_W + COEF_W; // one coefficient times a coordinate
    localparam int CTERM_W = COEF_W + 12;    // translation column times 1.0
    localparam int CLIP_W  = PROD_W + 2;     // sum of four terms
    localparam int MAG_W   = PROD_W;         // magnitude of a clip value
    localparam int FRAC_W  = 15;             // x * 2^15 / w gives half-NDC in Q.16
    localparam int NUM_W   = MAG_W + FRAC_W; // dividend and quotient width
    localparam int HALF_W  = NUM_W + 2;      // signed rounded quotient
    localparam int DIFF_W  = HALF_W + 1;
    localparam int VEL_W   = 20;
    localparam int REG_W   = 64;
    localparam int IDX_W   = 3;
    localparam int NUM_REGS = 6;
    localparam int IN_W    = 3 * POS_W;
    localparam int OUT_W   = 48;             // 43 bits of fields padded to bytes

    localparam logic [REG_W-1:0] ROW_X_RST = 64'h0000_0000_0000_1000;
    localparam logic [REG_W-1:0] ROW_Y_RST = 64'h0000_0000_1000_0000;
    localparam logic [REG_W-1:0] ROW_W_RST = 64'h1000_0000_0000_0000;

    localparam logic [IDX_W-1:0] REG_CUR_X  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CUR_Y  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CUR_W  = 3'd2;
    localparam logic [IDX_W-1:0] REG_PREV_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_PREV_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_PREV_W = 3'd5;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 20'sh7FFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 20'sh80000;

    // Flags that travel beside the dividers.
    typedef struct packed {
        logic [3:0] neg;
        logic       cur_zero;
        logic       prev_zero;
    } side_t;

endpackage

`default_nettype wire

[rtl/core/smv_divider.sv]
// ----------------------------------------------------------------------------
// smv_divider
// Pipelined restoring divider, one quotient bit per stage, with stall enable.
// ----------------------------------------------------------------------------
`default_nettype none

module smv_divider (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [smv_pkg::MAG_W-1:0]   dividend_mag,
    input  wire logic [smv_pkg::MAG_W-1:0]   divisor_mag,
    output logic      [smv_pkg::NUM_W-1:0]   quotient,
    output logic      [smv_pkg::MAG_W-1:0]   remainder,
    output logic      [smv_pkg::MAG_W-1:0]   divisor_out
);
    import smv_pkg::*;

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    logic [NUM_W-1:0] nq_reg  [0:NUM_W];
    logic [MAG_W-1:0] rem_reg [0:NUM_W];
    logic [MAG_W-1:0] dv_reg  [0:NUM_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg[0]  <= {dividend_mag, {FRAC_W{1'b0}}};
            rem_reg[0] <= '0;
            dv_reg[0]  <= divisor_mag;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [MAG_W:0]   trial;
        logic             ge;
        logic [MAG_W:0]   diff;
        assign trial = {rem_reg[k], nq_reg[k][NUM_W-1]};
        assign ge    = trial >= {1'b0, dv_reg[k]};
        assign diff  = trial - {1'b0, dv_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                nq_reg[k+1]  <= {nq_reg[k][NUM_W-2:0], ge};
                dv_reg[k+1]  <= dv_reg[k];
            end
        end
    end

    assign quotient    = nq_reg[NUM_W];
    assign remainder   = rem_reg[NUM_W];
    assign divisor_out = dv_reg[NUM_W];

endmodule

`default_nettype wire

[rtl/core/screen_motion_vector.sv]
// Path from an input transfer to its result: products, clip sums,
// a 56-stage divider pipeline, rounding, then difference and saturation.
// Throughput: one position per cycle; the bit-serial dividers are fully pipelined.
// The whole pipeline halts together while a result waits on m_tready.
// Reset (aresetn low, synchronous) clears all valid bits and loads identity matrices.
// ----------------------------------------------------------------------------
// screen_motion_vector
// Projects a world position through two view-projection matrices and gives
// the saturated screen-space UV velocity between them.
// ----------------------------------------------------------------------------
`default_nettype none

module screen_motion_vector (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pos_x [23:0], pos_y [47:24], pos_z [71:48]
    input  wire logic [smv_pkg::IN_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // vel_x [19:0], vel_y [39:20], cur_w_zero [40], prev_w_zero [41], clipped [42]
    output logic      [smv_pkg::OUT_W-1:0]     m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [smv_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [smv_pkg::REG_W-1:0]     cfg_wdata
);
    import smv_pkg::*;

    localparam int LAT = NUM_W + 5;

    logic [REG_W-1:0] row_reg [0:NUM_REGS-1];
    logic             en;
    logic [LAT-1:0]   vld_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[REG_CUR_X]  <= ROW_X_RST;
            row_reg[REG_CUR_Y]  <= ROW_Y_RST;
            row_reg[REG_CUR_W]  <= ROW_W_RST;
            row_reg[REG_PREV_X] <= ROW_X_RST;
            row_reg[REG_PREV_Y] <= ROW_Y_RST;
            row_reg[REG_PREV_W] <= ROW_W_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CUR_X:  row_reg[REG_CUR_X]  <= cfg_wdata;
                REG_CUR_Y:  row_reg[REG_CUR_Y]  <= cfg_wdata;
                REG_CUR_W:  row_reg[REG_CUR_W]  <= cfg_wdata;
                REG_PREV_X: row_reg[REG_PREV_X] <= cfg_wdata;
                REG_PREV_Y: row_reg[REG_PREV_Y] <= cfg_wdata;
                REG_PREV_W: row_reg[REG_PREV_W] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Stage 1: coefficient products.
    logic signed [PROD_W-1:0]  prod_reg  [0:NUM_REGS-1][0:2];
    logic signed [CTERM_W-1:0] cterm_reg [0:NUM_REGS-1];

    for (genvar r = 0; r < NUM_REGS; r++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            logic signed [COEF_W-1:0] coef;
            logic signed [POS_W-1:0]  pos;
            assign coef = row_reg[r][COEF_W*j +: COEF_W];
            assign pos  = s_tdata[POS_W*j +: POS_W];
            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_reg[r][j] <= PROD_W'(coef) * PROD_W'(pos);
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cterm_reg[r] <= {row_reg[r][COEF_W*3 +: COEF_W], 12'd0};
            end
        end
    end

    // Stage 2: clip-space sums.
    logic signed [CLIP_W-1:0] clip_reg [0:NUM_REGS-1];

    for (genvar r = 0; r < NUM_REGS; r++) begin : g_sum
        always_ff @(posedge aclk) begin
            if (en) begin
                clip_reg[r] <= CLIP_W'(prod_reg[r][0]) + CLIP_W'(prod_reg[r][1])
                             + CLIP_W'(prod_reg[r][2]) + CLIP_W'(cterm_reg[r]);
            end
        end
    end

    // Magnitudes into the dividers: lanes cur x, cur y, prev x, prev y.
    logic [MAG_W-1:0] mag [0:NUM_REGS-1];
    for (genvar r = 0; r < NUM_REGS; r++) begin : g_mag
        logic signed [CLIP_W-1:0] neg_val;
        assign neg_val = -clip_reg[r];
        assign mag[r]  = clip_reg[r][CLIP_W-1] ? neg_val[MAG_W-1:0]
                                               : clip_reg[r][MAG_W-1:0];
    end

    side_t side_in;
    assign side_in.neg[0]    = clip_reg[REG_CUR_X][CLIP_W-1]  ^ clip_reg[REG_CUR_W][CLIP_W-1];
    assign side_in.neg[1]    = clip_reg[REG_CUR_Y][CLIP_W-1]  ^ clip_reg[REG_CUR_W][CLIP_W-1];
    assign side_in.neg[2]    = clip_reg[REG_PREV_X][CLIP_W-1] ^ clip_reg[REG_PREV_W][CLIP_W-1];
    assign side_in.neg[3]    = clip_reg[REG_PREV_Y][CLIP_W-1] ^ clip_reg[REG_PREV_W][CLIP_W-1];
    assign side_in.cur_zero  = clip_reg[REG_CUR_W]  == '0;
    assign side_in.prev_zero = clip_reg[REG_PREV_W] == '0;

    side_t side_reg [0:NUM_W];
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 0; k < NUM_W; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    logic [NUM_W-1:0] quo [0:3];
    logic [MAG_W-1:0] rem [0:3];
    logic [MAG_W-1:0] dvo [0:3];

    smv_divider u_div_cx (.aclk, .en, .dividend_mag(mag[REG_CUR_X]),
        .divisor_mag(mag[REG_CUR_W]), .quotient(quo[0]), .remainder(rem[0]),
        .divisor_out(dvo[0]));
    smv_divider u_div_cy (.aclk, .en, .dividend_mag(mag[REG_CUR_Y]),
        .divisor_mag(mag[REG_CUR_W]), .quotient(quo[1]), .remainder(rem[1]),
        .divisor_out(dvo[1]));
    smv_divider u_div_px (.aclk, .en, .dividend_mag(mag[REG_PREV_X]),
        .divisor_mag(mag[REG_PREV_W]), .quotient(quo[2]), .remainder(rem[2]),
        .divisor_out(dvo[2]));
    smv_divider u_div_py (.aclk, .en, .dividend_mag(mag[REG_PREV_Y]),
        .divisor_mag(mag[REG_PREV_W]), .quotient(quo[3]), .remainder(rem[3]),
        .divisor_out(dvo[3]));

    // Rounding stage: round half away from zero, apply sign, force zero-w lanes.
    logic signed [HALF_W-1:0] half_reg [0:3];
    logic                     cz_reg, pz_reg;
    side_t                    side_out;
    assign side_out = side_reg[NUM_W];

    for (genvar l = 0; l < 4; l++) begin : g_round
        logic             up;
        logic [NUM_W:0]   q_rnd;
        logic             wz;
        assign up    = {rem[l], 1'b0} >= {1'b0, dvo[l]};
        assign q_rnd = {1'b0, quo[l]} + (NUM_W+1)'(up);
        assign wz    = (l < 2) ? side_out.cur_zero : side_out.prev_zero;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (wz) begin
                    half_reg[l] <= '0;
                end else if (side_out.neg[l]) begin
                    half_reg[l] <= HALF_W'(0) - {1'b0, q_rnd};
                end else begin
                    half_reg[l] <= {1'b0, q_rnd};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cz_reg <= side_out.cur_zero;
            pz_reg <= side_out.prev_zero;
        end
    end

    // Output stage: difference and saturation.
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [VEL_W-1:0]  vx_next, vy_next;
    logic                     hit_x, hit_y;

    assign dx = DIFF_W'(half_reg[0]) - DIFF_W'(half_reg[2]);
    assign dy = DIFF_W'(half_reg[1]) - DIFF_W'(half_reg[3]);

    always_comb begin
        hit_x = 1'b1;
        hit_y = 1'b1;
        if (dx > DIFF_W'(VEL_MAX)) begin
            vx_next = VEL_MAX;
        end else if (dx < DIFF_W'(VEL_MIN)) begin
            vx_next = VEL_MIN;
        end else begin
            vx_next = dx[VEL_W-1:0];
            hit_x   = 1'b0;
        end
        if (dy > DIFF_W'(VEL_MAX)) begin
            vy_next = VEL_MAX;
        end else if (dy < DIFF_W'(VEL_MIN)) begin
            vy_next = VEL_MIN;
        end else begin
            vy_next = dy[VEL_W-1:0];
            hit_y   = 1'b0;
        end
    end

    logic [OUT_W-1:0] out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= {5'd0, hit_x | hit_y, pz_reg, cz_reg, vy_next, vx_next};
        end
    end
    assign m_tdata = out_reg;

    // A result flagged as clipped sits on a rail in at least one component.
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[42] |->
            m_tdata[19:0] == VEL_MAX || m_tdata[19:0] == VEL_MIN ||
            m_tdata[39:20] == VEL_MAX || m_tdata[39:20] == VEL_MIN)
        else $error("clipped flag without a saturated component");

    // Both frames degenerate: both UVs are 0.5, so no motion.
    a_both_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40] && m_tdata[41] |->
            m_tdata[39:0] == '0 && !m_tdata[42])
        else $error("zero w on both frames gave nonzero velocity");

    // An accepted transfer enters the first stage.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted position lost at pipeline entry");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
